// File: rtl/core/aqot_pkg.sv
// ============================================================================
// aqot_pkg
// Shared types, codes and reset constants for the alternating quote order
// tracker: input and result word layouts, register indexes, action codes.
// ============================================================================
`default_nettype none

package aqot_pkg;

    // Live order table depth
    localparam int TABLE_DEPTH = 16;

    // Register indexes on the configuration port
    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] REG_SYMBOL     = 2'd0;
    localparam logic [1:0] REG_EXPIRY     = 2'd1;
    localparam logic [1:0] REG_MIN_GAP    = 2'd2;

    // Register reset values
    localparam logic [63:0] SYMBOL_RESET  = 64'd0;
    localparam logic [63:0] EXPIRY_RESET  = 64'd600000000000;
    localparam logic [63:0] MIN_GAP_RESET = 64'd10000;

    // Input opcodes
    localparam logic OP_BOOK = 1'b0;
    localparam logic OP_FILL = 1'b1;

    // Result action kinds
    localparam logic ACT_CANCEL = 1'b0;
    localparam logic ACT_ADD    = 1'b1;

    // Largest int64 price
    localparam logic [63:0] PRICE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Input word
    typedef struct packed {
        logic               opcode;
        logic [63:0]        event_time;
        logic signed [63:0] bid_price;
        logic signed [63:0] ask_price;
        logic [63:0]        filled_id;
    } item_t;

    // Result word
    typedef struct packed {
        logic               action_kind;
        logic [63:0]        action_id;
        logic [63:0]        symbol_out;
        logic signed [63:0] order_price;
        logic               buy_side;
        logic [63:0]        sent_time;
        logic               last_of_run;
    } result_t;

    // Shared compare unit status
    typedef struct packed {
        logic borrow;   // a < b
        logic ge;       // (a - b) mod 2^64 >= k
    } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/core/alternating_quote_order_tracker_top.sv
// ============================================================================
// alternating_quote_order_tracker_top
// Tracks live orders in a table in creation order. Fill words remove an id;
// book words cancel expired orders oldest first and then may place one order,
// alternating buy at bid and sell at ask.
//
//   channel   dir  handshake            payload
//   item      in   start / busy         item   (aqot_pkg::item_t)
//   result    out  valid (one cycle)    result (aqot_pkg::result_t)
//   config    in   cfg_write            cfg_index, cfg_data
//
// The scan reads one table entry per cycle through the single RAM read port,
// and one shared subtract/compare unit ages each entry and checks the
// placement gap. Results come out one per cycle at most, the last one in the
// first cycle with busy low. Invalid book words and fills with id zero finish
// in the accept cycle. Reset empties the table at once; the receiver cannot
// stall results.
// ============================================================================
`default_nettype none

module alternating_quote_order_tracker_top #(
    parameter int TABLE_DEPTH = aqot_pkg::TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire aqot_pkg::item_t                   item,
    output logic                                   valid,
    output aqot_pkg::result_t                      result,
    input  wire logic                              cfg_write,
    input  wire logic [aqot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [63:0]                       cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

    localparam logic signed [63:0] PRICE_MAX_S = aqot_pkg::PRICE_MAX;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_PLACE = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Control state
    logic [1:0]        state_reg,      state_next;
    logic [CW-1:0]     rd_idx_reg,     rd_idx_next;
    logic              rvld_reg,       rvld_next;
    logic [CW-1:0]     keep_reg,       keep_next;
    logic [CW-1:0]     count_reg,      count_next;
    logic [63:0]       next_id_reg,    next_id_next;
    logic              buy_turn_reg,   buy_turn_next;
    logic [63:0]       last_place_reg, last_place_next;
    logic              pend_vld_reg,   pend_vld_next;
    logic              valid_reg,      valid_next;
    logic              nomax_reg,      nomax_next;
    logic [63:0]       symbol_reg,     symbol_next;
    logic [63:0]       expiry_reg,     expiry_next;
    logic [63:0]       min_gap_reg,    min_gap_next;

    // Payload
    aqot_pkg::item_t   item_reg,       item_next;
    aqot_pkg::result_t pend_reg,       pend_next;
    aqot_pkg::result_t result_reg,     result_next;

    // Table RAM and compare unit
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [127:0]      ram_wdata;
    logic [127:0]      ram_rdata;
    logic [63:0]       ent_id;
    logic [63:0]       ent_time;
    logic [63:0]       cmp_b;
    logic [63:0]       cmp_k;
    aqot_pkg::cmp_res_t cmp;

    // Combinational helpers
    logic              accept;
    logic              issue;
    logic              book_ok;
    logic              place;
    logic              gen_vld;
    aqot_pkg::result_t gen;

    assign ent_id   = ram_rdata[127:64];
    assign ent_time = ram_rdata[63:0];

    aqot_ram #(
        .WIDTH (128),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Share the unit: gap check in place state, entry age otherwise
    assign cmp_b = (state_reg == ST_PLACE) ? last_place_reg : ent_time;
    assign cmp_k = (state_reg == ST_PLACE) ? min_gap_reg    : expiry_reg;

    aqot_cmp_unit u_cmp (
        .a   (item_reg.event_time),
        .b   (cmp_b),
        .k   (cmp_k),
        .res (cmp)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign issue  = (rd_idx_reg < count_reg);

    // Book sanity: 0 < bid < ask
    assign book_ok = !item.bid_price[63] && (item.bid_price != '0) &&
                     !item.ask_price[63] && (item.ask_price != '0) &&
                     ($signed(item.bid_price) < $signed(item.ask_price));

    assign place = nomax_reg && cmp.ge && (count_reg < DEPTH_CNT);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        rvld_next       = 1'b0;
        keep_next       = keep_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        buy_turn_next   = buy_turn_reg;
        last_place_next = last_place_reg;
        pend_vld_next   = pend_vld_reg;
        pend_next       = pend_reg;
        valid_next      = 1'b0;
        result_next     = pend_reg;
        nomax_next      = nomax_reg;
        item_next       = item_reg;
        ram_we          = 1'b0;
        ram_waddr       = keep_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        gen_vld         = 1'b0;
        gen             = '0;
        gen.symbol_out  = symbol_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next   = item;
                    nomax_next  = (item.bid_price != PRICE_MAX_S) &&
                                  (item.ask_price != PRICE_MAX_S);
                    rd_idx_next = '0;
                    keep_next   = '0;
                    if (item.opcode == aqot_pkg::OP_FILL)
                    begin
                        if (item.filled_id != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (book_ok)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                rvld_next   = issue;
                rd_idx_next = rd_idx_reg + CW'(issue);

                // Judge the entry read last cycle
                if (rvld_reg)
                begin
                    if (item_reg.opcode == aqot_pkg::OP_FILL)
                    begin
                        if (ent_id != item_reg.filled_id)
                        begin
                            ram_we    = 1'b1;
                            keep_next = keep_reg + CW'(1);
                        end
                    end
                    else if (!cmp.borrow && cmp.ge)
                    begin
                        gen_vld            = 1'b1;
                        gen.action_kind    = aqot_pkg::ACT_CANCEL;
                        gen.action_id      = ent_id;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        keep_next = keep_reg + CW'(1);
                    end
                end

                // Scan done: commit the compacted count
                if (!issue && !rvld_reg)
                begin
                    count_next = keep_reg;
                    state_next = (item_reg.opcode == aqot_pkg::OP_FILL) ? ST_IDLE
                                                                        : ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                if (place)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[AW-1:0];
                    ram_wdata       = {next_id_reg, item_reg.event_time};
                    count_next      = count_reg + CW'(1);
                    next_id_next    = next_id_reg + 64'd1;
                    buy_turn_next   = !buy_turn_reg;
                    last_place_next = item_reg.event_time;
                    gen_vld         = 1'b1;
                    gen.action_kind = aqot_pkg::ACT_ADD;
                    gen.action_id   = next_id_reg;
                    gen.order_price = buy_turn_reg ? item_reg.bid_price
                                                   : item_reg.ask_price;
                    gen.buy_side    = buy_turn_reg;
                    gen.sent_time   = item_reg.event_time;
                end
                state_next = ST_FLUSH;
            end

            ST_FLUSH:
            begin
                // Drain the held result as the last of the run
                if (pend_vld_reg)
                begin
                    valid_next              = 1'b1;
                    result_next.last_of_run = 1'b1;
                    pend_vld_next           = 1'b0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold each new result until the next one or the flush so the last one can be marked
        if (gen_vld)
        begin
            if (pend_vld_reg)
            begin
                valid_next              = 1'b1;
                result_next.last_of_run = 1'b0;
            end
            pend_next     = gen;
            pend_vld_next = 1'b1;
        end
    end

    // Configuration writes
    always_comb
    begin
        symbol_next  = symbol_reg;
        expiry_next  = expiry_reg;
        min_gap_next = min_gap_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                aqot_pkg::REG_SYMBOL:  symbol_next  = cfg_data;
                aqot_pkg::REG_EXPIRY:  expiry_next  = cfg_data;
                aqot_pkg::REG_MIN_GAP: min_gap_next = cfg_data;
                default:               symbol_next  = symbol_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            rvld_reg       <= 1'b0;
            keep_reg       <= '0;
            count_reg      <= '0;
            next_id_reg    <= 64'd1;
            buy_turn_reg   <= 1'b1;
            last_place_reg <= '0;
            pend_vld_reg   <= 1'b0;
            valid_reg      <= 1'b0;
            nomax_reg      <= 1'b0;
            symbol_reg     <= aqot_pkg::SYMBOL_RESET;
            expiry_reg     <= aqot_pkg::EXPIRY_RESET;
            min_gap_reg    <= aqot_pkg::MIN_GAP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            rvld_reg       <= rvld_next;
            keep_reg       <= keep_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            buy_turn_reg   <= buy_turn_next;
            last_place_reg <= last_place_next;
            pend_vld_reg   <= pend_vld_next;
            valid_reg      <= valid_next;
            nomax_reg      <= nomax_next;
            symbol_reg     <= symbol_next;
            expiry_reg     <= expiry_next;
            min_gap_reg    <= min_gap_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/aqot_ram.sv
// ============================================================================
// aqot_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module aqot_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/aqot_cmp_unit.sv
// ============================================================================
// aqot_cmp_unit
// Shared 64-bit subtract and threshold compare: forms a - b and tests the
// modular difference against a limit. Serves both the expiry scan and the
// placement gap check.
// ============================================================================
`default_nettype none

module aqot_cmp_unit (
    input  wire logic [63:0]       a,
    input  wire logic [63:0]       b,
    input  wire logic [63:0]       k,
    output aqot_pkg::cmp_res_t     res
);

    logic [64:0] diff;

    // Subtract with borrow, then compare against the limit
    always_comb
    begin
        diff       = {1'b0, a} - {1'b0, b};
        res.borrow = diff[64];
        res.ge     = (diff[63:0] >= k);
    end

endmodule

`default_nettype wire

// File: rtl/core/aqot_checker.sv
// ============================================================================
// aqot_checker
// Port-level checks on the order tracker: result timing against busy and the
// shape of cancel and add words.
// ============================================================================
`default_nettype none

module aqot_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              valid,
    input wire aqot_pkg::result_t result
);

    // A word that is not the last of its run comes while the block is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !result.last_of_run) |-> busy)
        else $error("non-final result outside a run");

    // The last word of a run is never followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && result.last_of_run) |=> !valid)
        else $error("result right after end of run");

    // No result in the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !valid)
        else $error("result right after accept");

    // An add always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (result.action_kind == aqot_pkg::ACT_ADD)) |-> result.last_of_run)
        else $error("add not last of run");

    // A cancel carries no price, side or time
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (result.action_kind == aqot_pkg::ACT_CANCEL)) |->
        ((result.order_price == '0) && !result.buy_side && (result.sent_time == '0)))
        else $error("cancel with add fields set");

endmodule

bind alternating_quote_order_tracker_top aqot_checker u_aqot_checker (.*);

`default_nettype wire

// File: sim/alternating_quote_order_tracker_top_test.sv
// ============================================================================
// alternating_quote_order_tracker_top_test
// Self-checking bench for the quote order tracker. A directed table covers
// book edge cases, fills and placement rules, then random book and fill
// words run under four register settings with varied sender idling. Every
// result word is checked field by field against typed plan words or the tracker.
// ============================================================================

module alternating_quote_order_tracker_top_test;

    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam int          STALL_LIMIT = 2000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        aqot_pkg::item_t   w;
        int                fixed_n;   // -1: use the tracker, else number of typed results
        aqot_pkg::result_t fixed_r;
    } plan_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    aqot_pkg::item_t                item = '0;
    logic                           valid;
    aqot_pkg::result_t              result;
    logic                           cfg_write = 1'b0;
    logic [aqot_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]                    cfg_data = '0;

    // Tracker state and register copies
    logic [63:0] live_ids [aqot_pkg::TABLE_DEPTH];
    logic [63:0] live_times [aqot_pkg::TABLE_DEPTH];
    int          live_count = 0;
    logic [63:0] id_next = 64'd1;
    logic        buy_next = 1'b1;
    logic [63:0] last_quote = 64'd0;
    logic [63:0] sym_reg = aqot_pkg::SYMBOL_RESET;
    logic [63:0] expiry_reg = aqot_pkg::EXPIRY_RESET;
    logic [63:0] gap_reg = aqot_pkg::MIN_GAP_RESET;

    aqot_pkg::result_t actions_due [$];
    plan_row_t         plan [$];
    int                fault_count = 0;
    int                stall_cycles = 0;
    int                idle_pct = 0;
    logic [63:0]       market_time = 64'd0;

    alternating_quote_order_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .valid     (valid),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Append one expected result word
    function automatic void queue_action(input aqot_pkg::result_t r);
        actions_due.insert(actions_due.size(), r);
    endfunction

    // Apply one word to the tracker; queue its actions when publish is set
    function automatic void track_word(input aqot_pkg::item_t w, input bit publish);
        logic signed [63:0] bid;
        logic signed [63:0] ask;
        logic [63:0]        t;
        logic [63:0]        since;
        int                 keep;
        int                 n;
        aqot_pkg::result_t  r;
        bid  = w.bid_price;
        ask  = w.ask_price;
        t    = w.event_time;
        keep = 0;
        n    = 0;
        if (w.opcode == aqot_pkg::OP_FILL)
        begin
            if (w.filled_id == 64'd0)
                return;
            for (int i = 0; i < live_count; i++)
            begin
                if (live_ids[i] != w.filled_id)
                begin
                    live_ids[keep]   = live_ids[i];
                    live_times[keep] = live_times[i];
                    keep++;
                end
            end
            live_count = keep;
            return;
        end
        if (bid <= 0 || ask <= 0 || bid >= ask)
            return;
        // Cancel aged orders oldest first, compact the rest
        for (int i = 0; i < live_count; i++)
        begin
            if (t >= live_times[i] && (t - live_times[i]) >= expiry_reg)
            begin
                r             = '0;
                r.action_kind = aqot_pkg::ACT_CANCEL;
                r.action_id   = live_ids[i];
                r.symbol_out  = sym_reg;
                if (publish)
                    queue_action(r);
                n++;
            end
            else
            begin
                live_ids[keep]   = live_ids[i];
                live_times[keep] = live_times[i];
                keep++;
            end
        end
        live_count = keep;
        // Place the next alternating quote if the rules allow
        since = t - last_quote;
        if (bid != aqot_pkg::PRICE_MAX && ask != aqot_pkg::PRICE_MAX &&
            since >= gap_reg && live_count < aqot_pkg::TABLE_DEPTH)
        begin
            r             = '0;
            r.action_kind = aqot_pkg::ACT_ADD;
            r.action_id   = id_next;
            r.symbol_out  = sym_reg;
            r.order_price = buy_next ? bid : ask;
            r.buy_side    = buy_next;
            r.sent_time   = t;
            if (publish)
                queue_action(r);
            n++;
            live_ids[live_count]   = id_next;
            live_times[live_count] = t;
            live_count++;
            id_next    = id_next + 64'd1;
            buy_next   = ~buy_next;
            last_quote = t;
        end
        if (publish && n > 0)
            actions_due[actions_due.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic aqot_pkg::item_t book(input logic [63:0] t,
                                             input logic [63:0] bid,
                                             input logic [63:0] ask);
        aqot_pkg::item_t w;
        w            = '0;
        w.opcode     = aqot_pkg::OP_BOOK;
        w.event_time = t;
        w.bid_price  = bid;
        w.ask_price  = ask;
        return w;
    endfunction

    function automatic aqot_pkg::item_t fill(input logic [63:0] id);
        aqot_pkg::item_t w;
        w           = '0;
        w.opcode    = aqot_pkg::OP_FILL;
        w.filled_id = id;
        return w;
    endfunction

    // Add result as it looks with the reset symbol, alone in its run
    function automatic aqot_pkg::result_t quote(input logic [63:0] id,
                                                input logic [63:0] price,
                                                input logic buy,
                                                input logic [63:0] t);
        aqot_pkg::result_t r;
        r             = '0;
        r.action_kind = aqot_pkg::ACT_ADD;
        r.action_id   = id;
        r.symbol_out  = aqot_pkg::SYMBOL_RESET;
        r.order_price = price;
        r.buy_side    = buy;
        r.sent_time   = t;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic void plan_row(input aqot_pkg::item_t w, input int n,
                                     input aqot_pkg::result_t r);
        plan_row_t row;
        row.w       = w;
        row.fixed_n = n;
        row.fixed_r = r;
        plan.insert(plan.size(), row);
    endfunction

    // Random word: mostly sane quotes on a rising clock, some noise
    function automatic aqot_pkg::item_t draw_word(input int step_max);
        aqot_pkg::item_t w;
        int              pick;
        w.opcode     = aqot_pkg::OP_BOOK;
        w.event_time = {$urandom, $urandom};
        w.bid_price  = {$urandom, $urandom};
        w.ask_price  = {$urandom, $urandom};
        w.filled_id  = {$urandom, $urandom};
        if ($urandom_range(99) < 15)
        begin
            w.opcode = aqot_pkg::OP_FILL;
            pick     = $urandom_range(99);
            if (pick < 10)
                w.filled_id = 64'd0;
            else if (pick < 70 && live_count > 0)
                w.filled_id = live_ids[$urandom_range(live_count - 1)];
            return w;
        end
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            market_time  = market_time + 64'($urandom_range(step_max));
            w.event_time = market_time;
        end
        else if (pick < 90)
        begin
            w.event_time = market_time - 64'($urandom_range(5000, 1));
        end
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            w.bid_price = 64'($urandom_range(1000000, 1));
            w.ask_price = w.bid_price + 64'($urandom_range(1000, 1));
        end
        else if (pick < 85)
        begin
            w.bid_price = 64'($urandom_range(1000000, 1));
            w.ask_price = aqot_pkg::PRICE_MAX;
        end
        return w;
    endfunction

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_word(input aqot_pkg::item_t w);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
    endtask

    // Drain all expected results and let a silent word finish
    task automatic settle();
        while (actions_due.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (aqot_pkg::TABLE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic load_regs(input logic [63:0] symbol, input logic [63:0] expiry,
                             input logic [63:0] gap);
        cfg_write <= 1'b1;
        cfg_index <= aqot_pkg::REG_SYMBOL;
        cfg_data  <= symbol;
        @(posedge clk);
        sym_reg   = symbol;
        cfg_index <= aqot_pkg::REG_EXPIRY;
        cfg_data  <= expiry;
        @(posedge clk);
        expiry_reg = expiry;
        cfg_index <= aqot_pkg::REG_MIN_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        gap_reg   = gap;
        // Unused index must be dropped by the block
        cfg_index <= REG_UNUSED;
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input int words, input int idle, input int step_max);
        aqot_pkg::item_t w;
        idle_pct = idle;
        repeat (words)
        begin
            w = draw_word(step_max);
            send_word(w);
            track_word(w, 1'b1);
        end
        start <= 1'b0;
        settle();
    endtask

    function automatic void note_fault(input string why, input aqot_pkg::result_t want,
                                       input aqot_pkg::result_t got);
        if (fault_count < 10)
        begin
            $display("%0t %s: kind %h/%h id %h/%h sym %h/%h", $time, why,
                     want.action_kind, got.action_kind, want.action_id, got.action_id,
                     want.symbol_out, got.symbol_out);
            $display("    price %h/%h buy %h/%h sent %h/%h last %h/%h",
                     want.order_price, got.order_price, want.buy_side, got.buy_side,
                     want.sent_time, got.sent_time, want.last_of_run, got.last_of_run);
        end
        fault_count++;
    endfunction

    // Check each result word against the oldest expectation; watch for stalls
    always @(posedge clk)
    begin
        aqot_pkg::result_t want;
        if (valid)
        begin
            if (actions_due.size() == 0)
            begin
                note_fault("unexpected result (want/got)", '0, result);
            end
            else
            begin
                want = actions_due.pop_front();
                if (want.action_kind !== result.action_kind ||
                    want.action_id   !== result.action_id   ||
                    want.symbol_out  !== result.symbol_out  ||
                    want.order_price !== result.order_price ||
                    want.buy_side    !== result.buy_side    ||
                    want.sent_time   !== result.sent_time   ||
                    want.last_of_run !== result.last_of_run)
                    note_fault("result mismatch (want/got)", want, result);
            end
        end
        if (!rst_n || valid || (start && !busy))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run with reset register values
        plan_row(book(64'd20000, 64'd100, 64'd200), 1,
                 quote(64'd1, 64'd100, 1'b1, 64'd20000));
        plan_row(book(64'd25000, 64'd100, 64'd200), 0, '0);  // inside min gap
        plan_row(book(64'd40000, 64'd101, 64'd102), 1,
                 quote(64'd2, 64'd102, 1'b0, 64'd40000));
        plan_row(book(64'd41000, 64'd200, 64'd100), 0, '0);  // crossed
        plan_row(book(64'd42000, 64'd150, 64'd150), 0, '0);  // locked
        plan_row(book(64'd43000, 64'd0, 64'd5), 0, '0);      // zero bid
        plan_row(book(64'd44000, 64'h8000_0000_0000_0000, aqot_pkg::PRICE_MAX), 0, '0);
        plan_row(book(64'd45000, 64'd5, 64'h8000_0000_0000_0000), 0, '0);
        plan_row(book(64'd60000, 64'd1, aqot_pkg::PRICE_MAX), 0, '0);  // max price
        plan_row(fill(64'd0), 0, '0);
        plan_row(fill(64'd1), 0, '0);
        plan_row(fill(ALL_ONES), 0, '0);
        plan_row(book(64'd80000, 64'd1, aqot_pkg::PRICE_MAX - 64'd1), 1,
                 quote(64'd3, 64'd1, 1'b1, 64'd80000));
        // Age exactly at expiry cancels, then a quote follows
        plan_row(book(64'd600000040000, 64'd500, 64'd600), -1, '0);
        // Entries newer than the word stay; gap wraps around
        plan_row(book(64'd50000, 64'd10, 64'd20), -1, '0);
        plan_row(book(ALL_ONES, 64'd1000, aqot_pkg::PRICE_MAX - 64'd1), -1, '0);
        plan_row(book(64'd0, 64'd5, 64'd6), -1, '0);
        plan_row(fill(64'd6), -1, '0);
        plan_row(book(64'd700000000000, aqot_pkg::PRICE_MAX - 64'd1,
                      aqot_pkg::PRICE_MAX), -1, '0);

        foreach (plan[k])
        begin
            send_word(plan[k].w);
            if (plan[k].fixed_n < 0)
                track_word(plan[k].w, 1'b1);
            else
            begin
                track_word(plan[k].w, 1'b0);
                if (plan[k].fixed_n > 0)
                    queue_action(plan[k].fixed_r);
            end
        end
        start <= 1'b0;
        settle();

        // Random phases across register extremes and idling patterns
        market_time = 64'd800000000000;
        load_regs(ALL_ONES, 64'd5000, 64'd0);
        run_phase(70, 0, 3000);
        load_regs({$urandom, $urandom}, ALL_ONES, 64'd0);
        run_phase(70, 75, 1000);
        load_regs(64'd0, 64'd0, ALL_ONES);
        run_phase(40, 0, 3000);
        load_regs({$urandom, $urandom}, 64'd30000, 64'd2000);
        run_phase(75, 11, 3000);

        if (fault_count == 0 && actions_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/aqot_pkg.sv
rtl/core/aqot_ram.sv
rtl/core/aqot_cmp_unit.sv
rtl/core/alternating_quote_order_tracker_top.sv
rtl/core/aqot_checker.sv
sim/alternating_quote_order_tracker_top_test.sv
